### rtl/sglpm_pkg.sv
// ----------------------------------------------------------------------------
// Sparse grid page map package
// Shared widths, reset values and codes for the two-level sparse page map.
// ----------------------------------------------------------------------------
package sglpm_pkg;

  // Default geometry; the top level exposes these as parameters.
  localparam int DEF_MAP_BITS   = 14;
  localparam int DEF_PAGE_BITS  = 10;
  localparam int DEF_CELL_BITS  = 7;
  localparam int DEF_POOL_PAGES = 64;

  localparam int COORD_W    = 16;
  localparam int VALUE_W    = 8;
  localparam int CFG_W      = 8;
  localparam int CFG_ADDR_W = 1;

  // Depth of the queue between front and back; must be a power of two.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [VALUE_W-1:0] EMPTY_CELL     = 8'hFF;
  localparam logic [CFG_W-1:0]   KEEP_ABOVE_RST = 8'd60;
  localparam logic [CFG_W-1:0]   MARK_STEP_RST  = 8'd50;

  typedef enum logic {
    CMD_MARK  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OUTSIDE   = 2'd1,
    ST_NO_PAGE   = 2'd2,
    ST_POOL_FULL = 2'd3
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_KEEP_ABOVE = 1'b0,
    REG_MARK_STEP  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_DIR,
    BS_FILL,
    BS_CELL
  } back_state_t;

endpackage

### rtl/sglpm_front.sv
// ----------------------------------------------------------------------------
// Sparse grid page map front end
// Accepts transactions, checks the map bounds and splits the coordinates
// into directory and cell indexes.
// ----------------------------------------------------------------------------
module sglpm_front #(
  parameter int MAP_BITS  = sglpm_pkg::DEF_MAP_BITS,
  parameter int PAGE_BITS = sglpm_pkg::DEF_PAGE_BITS,
  parameter int CELL_BITS = sglpm_pkg::DEF_CELL_BITS,
  localparam int ITEM_W   = 2 + 2 * (MAP_BITS - CELL_BITS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              enable,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [31:0]       in_coords,
  output logic              item_valid,
  input  logic              item_ready,
  output logic [ITEM_W-1:0] item
);
  import sglpm_pkg::*;

  localparam int DIR_IDX_W  = 2 * (MAP_BITS - PAGE_BITS);
  localparam int CELL_IDX_W = 2 * (PAGE_BITS - CELL_BITS);

  typedef struct packed {
    cmd_t                  cmd;
    logic                  outside;
    logic [DIR_IDX_W-1:0]  dir_idx;
    logic [CELL_IDX_W-1:0] cell_idx;
  } item_t;

  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;
  item_t              classified;
  item_t              held;
  logic               held_valid;

  assign x = in_coords[COORD_W-1:0];
  assign y = in_coords[2*COORD_W-1:COORD_W];

  // Negative coordinates and anything at or beyond the map side are outside.
  always_comb begin
    classified.cmd      = cmd_t'(in_cmd);
    classified.outside  = x[COORD_W-1] | y[COORD_W-1] |
                          ((x >> MAP_BITS) != '0) | ((y >> MAP_BITS) != '0);
    classified.dir_idx  = {y[MAP_BITS-1:PAGE_BITS], x[MAP_BITS-1:PAGE_BITS]};
    classified.cell_idx = {y[PAGE_BITS-1:CELL_BITS], x[PAGE_BITS-1:CELL_BITS]};
  end

  assign in_ready   = enable && (!held_valid || item_ready);
  assign item_valid = held_valid;
  assign item       = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (item_ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= classified;
    end
  end

endmodule

### rtl/sglpm_queue.sv
// ----------------------------------------------------------------------------
// Sparse grid page map queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module sglpm_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_pop,
  output logic [WIDTH-1:0] rd_data
);
  import sglpm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

### rtl/sglpm_back.sv
// ----------------------------------------------------------------------------
// Sparse grid page map back end
// Sequencer that owns the page directory, the page pool and the cell store.
// ----------------------------------------------------------------------------
module sglpm_back #(
  parameter int MAP_BITS   = sglpm_pkg::DEF_MAP_BITS,
  parameter int PAGE_BITS  = sglpm_pkg::DEF_PAGE_BITS,
  parameter int CELL_BITS  = sglpm_pkg::DEF_CELL_BITS,
  parameter int POOL_PAGES = sglpm_pkg::DEF_POOL_PAGES,
  localparam int ITEM_W    = 2 + 2 * (MAP_BITS - CELL_BITS)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [sglpm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sglpm_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                             q_valid,
  input  logic [ITEM_W-1:0]                q_item,
  output logic                             q_pop,
  output logic                             init_done,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sglpm_pkg::VALUE_W-1:0]    out_value,
  output logic [1:0]                       out_status
);
  import sglpm_pkg::*;

  localparam int DIR_IDX_W  = 2 * (MAP_BITS - PAGE_BITS);
  localparam int DIR_DEPTH  = 1 << DIR_IDX_W;
  localparam int CELL_IDX_W = 2 * (PAGE_BITS - CELL_BITS);
  localparam int PG_W       = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int USED_W     = $clog2(POOL_PAGES + 1);
  localparam int CA_W       = PG_W + CELL_IDX_W;
  localparam int CELL_DEPTH = POOL_PAGES * (1 << CELL_IDX_W);

  typedef struct packed {
    cmd_t                  cmd;
    logic                  outside;
    logic [DIR_IDX_W-1:0]  dir_idx;
    logic [CELL_IDX_W-1:0] cell_idx;
  } item_t;

  typedef struct packed {
    logic            valid;
    logic [PG_W-1:0] page;
  } dir_entry_t;

  // Memories
  dir_entry_t         dir_mem  [DIR_DEPTH];
  logic [VALUE_W-1:0] cell_mem [CELL_DEPTH];

  back_state_t           state;
  back_state_t           state_next;
  item_t                 head;
  item_t                 cur;
  logic [DIR_IDX_W-1:0]  clr_idx;
  logic [CELL_IDX_W-1:0] fill_idx;
  logic [USED_W-1:0]     pages_used;
  logic [PG_W-1:0]       page;
  logic                  fresh;
  logic [CFG_W-1:0]      keep_above;
  logic [CFG_W-1:0]      mark_step;

  dir_entry_t            dir_rd;
  logic                  dir_we;
  logic [DIR_IDX_W-1:0]  dir_waddr;
  dir_entry_t            dir_wdata;
  logic [DIR_IDX_W-1:0]  dir_raddr;

  logic [VALUE_W-1:0]    cell_rd;
  logic                  cell_we;
  logic [CA_W-1:0]       cell_waddr;
  logic [VALUE_W-1:0]    cell_wdata;
  logic [CA_W-1:0]       cell_raddr;

  logic                  out_free;
  logic                  ld_out;
  logic [VALUE_W-1:0]    ld_value;
  status_t               ld_status;
  logic                  alloc;
  logic [PG_W-1:0]       new_page;
  logic [VALUE_W-1:0]    base;
  logic [VALUE_W-1:0]    new_value;

  assign head      = item_t'(q_item);
  assign out_free  = !out_valid || out_ready;
  assign init_done = (state != BS_CLEAR);
  assign new_page  = pages_used[PG_W-1:0];

  // A fresh page reads as all empty cells without touching the store.
  assign base = fresh ? EMPTY_CELL : cell_rd;

  always_comb begin
    if (cur.cmd == CMD_QUERY) begin
      new_value = base;
    end else if (base > keep_above) begin
      new_value = (base > mark_step) ? (base - mark_step) : '0;
    end else begin
      new_value = '0;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    dir_we     = 1'b0;
    dir_waddr  = clr_idx;
    dir_wdata  = '0;
    dir_raddr  = head.dir_idx;
    cell_we    = 1'b0;
    cell_waddr = {page, fill_idx};
    cell_wdata = EMPTY_CELL;
    cell_raddr = {dir_rd.page, cur.cell_idx};
    ld_out     = 1'b0;
    ld_value   = EMPTY_CELL;
    ld_status  = ST_OK;
    alloc      = 1'b0;
    unique case (state)
      BS_CLEAR: begin
        dir_we = 1'b1;
        if (clr_idx == '1) begin
          state_next = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (head.outside) begin
            ld_out    = 1'b1;
            ld_status = ST_OUTSIDE;
          end else begin
            state_next = BS_DIR;
          end
        end
      end
      BS_DIR: begin
        if (dir_rd.valid) begin
          state_next = BS_CELL;
        end else if (cur.cmd == CMD_QUERY) begin
          ld_out     = 1'b1;
          ld_status  = ST_NO_PAGE;
          state_next = BS_IDLE;
        end else if (pages_used == USED_W'(POOL_PAGES)) begin
          ld_out     = 1'b1;
          ld_status  = ST_POOL_FULL;
          state_next = BS_IDLE;
        end else begin
          alloc           = 1'b1;
          dir_we          = 1'b1;
          dir_waddr       = cur.dir_idx;
          dir_wdata.valid = 1'b1;
          dir_wdata.page  = new_page;
          state_next      = BS_FILL;
        end
      end
      BS_FILL: begin
        cell_we = 1'b1;
        if (fill_idx == '1) begin
          state_next = BS_CELL;
        end
      end
      BS_CELL: begin
        ld_out     = 1'b1;
        ld_value   = new_value;
        ld_status  = ST_OK;
        state_next = BS_IDLE;
        if (cur.cmd == CMD_MARK) begin
          cell_we    = 1'b1;
          cell_waddr = {page, cur.cell_idx};
          cell_wdata = new_value;
        end
      end
      default: begin
        state_next = BS_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      pages_used <= '0;
      out_valid  <= 1'b0;
      keep_above <= KEEP_ABOVE_RST;
      mark_step  <= MARK_STEP_RST;
    end else begin
      if (state == BS_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (alloc) begin
        pages_used <= pages_used + 1'b1;
      end
      if (ld_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wen) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_KEEP_ABOVE: keep_above <= cfg_wdata;
          REG_MARK_STEP:  mark_step  <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= head;
    end
    if (state == BS_DIR && dir_rd.valid) begin
      page  <= dir_rd.page;
      fresh <= 1'b0;
    end
    if (alloc) begin
      page     <= new_page;
      fresh    <= 1'b1;
      fill_idx <= '0;
    end else if (state == BS_FILL) begin
      fill_idx <= fill_idx + 1'b1;
    end
    if (ld_out) begin
      out_value  <= ld_value;
      out_status <= ld_status;
    end
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    dir_rd <= dir_mem[dir_raddr];
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rd <= cell_mem[cell_raddr];
  end

endmodule

### rtl/sparse_grid_lazy_page_map_unit.sv
// ----------------------------------------------------------------------------
// Sparse grid lazy page map unit
// Two-level sparse map of byte cells with on-demand page allocation.
// ----------------------------------------------------------------------------
// Each transaction on the input stream either marks a point of the square
// world (side 2^MAP_BITS) or queries it, and produces exactly one result
// transaction, in order. The coarse coordinate bits pick a page directory
// entry; a mark that lands on a page with no entry takes the next page of a
// fixed pool of POOL_PAGES pages, fills it with 255 and then lowers the cell:
// a cell above keep_above loses mark_step (saturating at zero), any other
// cell becomes zero. A query returns the cell, or 255 with status "page not
// allocated". Points outside the map give 255 with status "outside map", and
// a mark that needs a page when the pool is spent gives 255 with status
// "pool full". Pages are never released until reset.
//
// Sequencing: a point outside the map is answered from the idle state. A
// query that finds no page and a mark refused because the pool is spent go
// through the back-end sequencer as a directory read, then the result. Any
// other transaction goes through the sequencer as a directory read, a cell
// read, then the result, with the cell write for a mark; a mark that allocates
// a page first fills every cell of the page (64 with the default geometry)
// with 255, one cell a cycle, through the single write port of the cell store.
// After reset the directory is cleared one entry a cycle, all
// 2^(2*(MAP_BITS-PAGE_BITS)) entries (256 by default), during which s_axis_tready stays low;
// configuration writes are taken throughout. The front end and a two-entry
// queue keep accepting input until full while the back end works or while a
// result waits on m_axis_tready. Write configuration only while the unit is idle.
// The geometry must satisfy MAP_BITS > PAGE_BITS > CELL_BITS.
// ----------------------------------------------------------------------------
module sparse_grid_lazy_page_map_unit #(
  parameter int MAP_BITS   = sglpm_pkg::DEF_MAP_BITS,
  parameter int PAGE_BITS  = sglpm_pkg::DEF_PAGE_BITS,
  parameter int CELL_BITS  = sglpm_pkg::DEF_CELL_BITS,
  parameter int POOL_PAGES = sglpm_pkg::DEF_POOL_PAGES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [sglpm_pkg::CFG_ADDR_W-1:0] cfg_addr,   // 0 keep_above, 1 mark_step
  input  logic [sglpm_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,  // x_coord[15:0], y_coord[31:16]
  input  logic [0:0]                       s_axis_tuser,  // command[0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // cell_value[7:0]
  output logic [1:0]                       m_axis_tuser   // status[1:0]
);
  import sglpm_pkg::*;

  localparam int ITEM_W = 2 + 2 * (MAP_BITS - CELL_BITS);

  logic              init_done;
  logic              f_valid;
  logic              f_ready;
  logic [ITEM_W-1:0] f_item;
  logic              q_valid;
  logic              q_pop;
  logic [ITEM_W-1:0] q_item;

  // Front end: bounds check and index split, one transaction a cycle when not stalled.
  sglpm_front #(
    .MAP_BITS  (MAP_BITS),
    .PAGE_BITS (PAGE_BITS),
    .CELL_BITS (CELL_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .enable     (init_done),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (s_axis_tuser[0]),
    .in_coords  (s_axis_tdata),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  // Decouples the front end from the back-end sequencer.
  sglpm_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_item),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_item)
  );

  // Back end: directory, page pool and cell store, with the result register.
  sglpm_back #(
    .MAP_BITS   (MAP_BITS),
    .PAGE_BITS  (PAGE_BITS),
    .CELL_BITS  (CELL_BITS),
    .POOL_PAGES (POOL_PAGES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .init_done  (init_done),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_value  (m_axis_tdata),
    .out_status (m_axis_tuser)
  );

endmodule

### rtl/sglpm_checker.sv
// ----------------------------------------------------------------------------
// Sparse grid page map checker
// Port-level assertions for the sparse page map unit, bound to the top level.
// ----------------------------------------------------------------------------
module sglpm_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser
);
  import sglpm_pkg::*;

  // The cycle after reset shows no result.
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // Every non-ok status carries the empty cell value.
  a_fail_is_empty: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == EMPTY_CELL))
    else $error("failed transaction without empty cell value");

  // A stalled result holds its value and status.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // A result leaves only after it was taken.
  a_out_taken: assert property (@(posedge clk) disable iff (rst)
    ($fell(m_axis_tvalid) && !$past(rst)) |-> $past(m_axis_tready))
    else $error("result dropped without handshake");

endmodule

bind sparse_grid_lazy_page_map_unit sglpm_checker u_checker (.*);

### verif/sparse_grid_lazy_page_map_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse grid lazy page map unit testbench
// Drives mark and query transactions into the page map, predicts every result
// with a behavioral copy of the directory, the page pool and the cell store,
// and compares each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module sparse_grid_lazy_page_map_unit_test;
  import sglpm_pkg::*;

  // Geometry of the instance under test (package defaults).
  localparam int MAP_BITS       = DEF_MAP_BITS;
  localparam int PAGE_BITS      = DEF_PAGE_BITS;
  localparam int CELL_BITS      = DEF_CELL_BITS;
  localparam int POOL_PAGES     = DEF_POOL_PAGES;
  localparam int MAP_SIDE       = 1 << MAP_BITS;
  localparam int DIR_SIDE_BITS  = MAP_BITS - PAGE_BITS;
  localparam int DIR_SIDE       = 1 << DIR_SIDE_BITS;
  localparam int DIR_ENTRIES    = 1 << (2 * DIR_SIDE_BITS);
  localparam int PAGE_SIDE_BITS = PAGE_BITS - CELL_BITS;
  localparam int PAGE_CELLS     = 1 << (2 * PAGE_SIDE_BITS);
  localparam int CELL_MASK      = (1 << PAGE_SIDE_BITS) - 1;
  localparam int PAGE_SPAN      = 1 << PAGE_BITS;

  // The run is declared hung after this many cycles without any transaction.
  // It covers the directory clear after reset, the long receiver hold-off,
  // page fills and the longest idle gaps with a wide margin.
  localparam int STALL_LIMIT    = 5000;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 20;
  localparam int TOUCHED_KEEP   = 48;

  // How busy a side of the stream is: never idle, idle a random gap after every
  // transaction, or only now and then.
  typedef enum int {
    PACE_NONE,
    PACE_BUSY,
    PACE_SPARSE
  } pace_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
  } cell_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata;   // x_coord[15:0], y_coord[31:16]
  logic [0:0]            s_axis_tuser;   // command[0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;   // cell_value[7:0]
  logic [1:0]            m_axis_tuser;   // status[1:0]

  sparse_grid_lazy_page_map_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Behavioral copy of the map state. The cell store is only ever read in a
  // page that has been filled, so it needs no reset value here.
  bit                 page_valid [DIR_ENTRIES] = '{default: 1'b0};
  int                 page_slot  [DIR_ENTRIES] = '{default: 0};
  int                 pages_taken = 0;
  logic [VALUE_W-1:0] cell_mem [POOL_PAGES * PAGE_CELLS];
  logic [CFG_W-1:0]   keep_above_q = KEEP_ABOVE_RST;
  logic [CFG_W-1:0]   mark_step_q  = MARK_STEP_RST;

  cell_result_t expected_cells[$];
  logic [31:0]  touched_points[$];   // in-map points that were marked

  int    mismatch_count = 0;
  int    stall_cycles = 0;
  int    sink_hold_cycles = 0;
  pace_t src_pace = PACE_BUSY;
  pace_t sink_pace = PACE_BUSY;

  // Applies one transaction to the behavioral map and returns its result.
  function automatic cell_result_t predict_cell_access(cmd_t cmd, logic [15:0] xr,
                                                        logic [15:0] yr);
    cell_result_t r;
    int xi;
    int yi;
    int dir_idx;
    int cell_idx;
    int addr;
    logic [VALUE_W-1:0] v;
    r.value  = EMPTY_CELL;
    r.status = ST_OK;
    xi = int'($signed(xr));
    yi = int'($signed(yr));
    if (xi < 0 || yi < 0 || xi >= MAP_SIDE || yi >= MAP_SIDE) begin
      r.status = ST_OUTSIDE;
    end else begin
      dir_idx  = (xi >> PAGE_BITS) + ((yi >> PAGE_BITS) << DIR_SIDE_BITS);
      cell_idx = ((xi >> CELL_BITS) & CELL_MASK)
                 + (((yi >> CELL_BITS) & CELL_MASK) << PAGE_SIDE_BITS);
      if (!page_valid[dir_idx]) begin
        if (cmd == CMD_QUERY) begin
          r.status = ST_NO_PAGE;
        end else if (pages_taken >= POOL_PAGES) begin
          r.status = ST_POOL_FULL;
        end else begin
          // First touch: take the next pool page and fill it with empty cells.
          page_valid[dir_idx] = 1'b1;
          page_slot[dir_idx]  = pages_taken;
          for (int c = 0; c < PAGE_CELLS; c++) begin
            cell_mem[pages_taken * PAGE_CELLS + c] = EMPTY_CELL;
          end
          pages_taken++;
        end
      end
      if (r.status == ST_OK) begin
        addr = page_slot[dir_idx] * PAGE_CELLS + cell_idx;
        v = cell_mem[addr];
        if (cmd == CMD_MARK) begin
          // Above the threshold a mark takes off one step, clamped at zero;
          // at or below it the cell is cleared outright.
          if (v > keep_above_q) begin
            v = (v > mark_step_q) ? v - mark_step_q : '0;
          end else begin
            v = '0;
          end
          cell_mem[addr] = v;
        end
        r.value = v;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] pack_point(int x, int y);
    return {16'(y), 16'(x)};
  endfunction

  // A point of the page behind directory entry dir_idx, offset within it.
  function automatic logic [31:0] point_in_page(int dir_idx, int ox, int oy);
    return pack_point((dir_idx % DIR_SIDE) * PAGE_SPAN + ox,
                      (dir_idx / DIR_SIDE) * PAGE_SPAN + oy);
  endfunction

  function automatic int draw_gap(pace_t pace);
    case (pace)
      PACE_NONE: return 0;
      PACE_BUSY: return $urandom_range(0, 18);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  function automatic pace_t draw_pace();
    case ($urandom_range(0, 2))
      0:       return PACE_NONE;
      1:       return PACE_BUSY;
      default: return PACE_SPARSE;
    endcase
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  // Random point: mostly revisits of marked cells and their pages so that
  // cells walk down to zero, some fresh points, and a tenth off the map.
  function automatic logic [31:0] pick_point();
    int sel;
    logic [31:0] p;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      case ($urandom_range(0, 3))
        0: p = $urandom();
        1: p = pack_point(-$urandom_range(1, 32768), $urandom_range(0, MAP_SIDE - 1));
        2: p = pack_point($urandom_range(0, MAP_SIDE - 1), $urandom_range(MAP_SIDE, 32767));
        default: p = pack_point($urandom_range(0, 1) ? 32767 : -32768,
                                $urandom_range(0, 1) ? -1 : MAP_SIDE);
      endcase
    end else if (sel < 45 && touched_points.size() > 0) begin
      p = touched_points[$urandom_range(0, touched_points.size() - 1)];
    end else if (sel < 65 && touched_points.size() > 0) begin
      p = touched_points[$urandom_range(0, touched_points.size() - 1)];
      p[PAGE_BITS-1:0]       = PAGE_BITS'($urandom());
      p[16+PAGE_BITS-1:16]   = PAGE_BITS'($urandom());
    end else begin
      p = pack_point($urandom_range(0, MAP_SIDE - 1), $urandom_range(0, MAP_SIDE - 1));
    end
    return p;
  endfunction

  // Offers one transaction after a random idle gap and records its
  // prediction at the edge where it is accepted.
  task automatic send_item(input cmd_t cmd, input logic [31:0] point);
    int gap;
    cell_result_t r;
    gap = draw_gap(src_pace);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= point;
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = predict_cell_access(cmd, point[15:0], point[31:16]);
    expected_cells.push_back(r);
    if (cmd == CMD_MARK && r.status == ST_OK) begin
      touched_points.push_back(point);
      if (touched_points.size() > TOUCHED_KEEP) void'(touched_points.pop_front());
    end
  endtask

  // Stops offering input and waits until every predicted result has come
  // back, then lets the back end settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_cells.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers on back-to-back edges, keep_above first; call only when drained.
  task automatic set_config(input logic [CFG_W-1:0] keep_above,
                            input logic [CFG_W-1:0] mark_step);
    cfg_wen   <= 1'b1;
    cfg_addr  <= REG_KEEP_ABOVE;
    cfg_wdata <= keep_above;
    @(posedge clk);
    keep_above_q = keep_above;
    cfg_addr  <= REG_MARK_STEP;
    cfg_wdata <= mark_step;
    @(posedge clk);
    mark_step_q = mark_step;
    cfg_wen <= 1'b0;
  endtask

  // Reset thresholds: query before allocation, first touch, repeated marks
  // down to zero, cells of the same and other pages, map corners and
  // points off the map with every sign and extreme.
  task automatic test_directed();
    src_pace  = PACE_BUSY;
    sink_pace = PACE_BUSY;
    send_item(CMD_QUERY, pack_point(0, 0));
    send_item(CMD_MARK,  pack_point(0, 0));
    send_item(CMD_QUERY, pack_point(0, 0));
    repeat (5) send_item(CMD_MARK, pack_point(0, 0));
    send_item(CMD_QUERY, pack_point(127, 127));
    send_item(CMD_QUERY, pack_point(128, 0));
    send_item(CMD_QUERY, pack_point(0, PAGE_SPAN - 1));
    send_item(CMD_MARK,  pack_point(MAP_SIDE - 1, MAP_SIDE - 1));
    send_item(CMD_QUERY, pack_point(MAP_SIDE - 1, MAP_SIDE - 1));
    send_item(CMD_QUERY, pack_point(MAP_SIDE - 1, 0));
    send_item(CMD_MARK,  pack_point(-1, 0));
    send_item(CMD_QUERY, pack_point(0, -1));
    send_item(CMD_MARK,  pack_point(MAP_SIDE, 0));
    send_item(CMD_QUERY, pack_point(0, MAP_SIDE));
    send_item(CMD_MARK,  pack_point(-32768, -32768));
    send_item(CMD_QUERY, pack_point(32767, 32767));
    send_item(CMD_MARK,  pack_point(32767, -32768));
    send_item(CMD_QUERY, pack_point(-32768, 32767));
    send_item(CMD_MARK,  pack_point(PAGE_SPAN - 1, PAGE_SPAN));
  endtask

  // Walks the threshold and step through their extremes. Each setting gets a
  // fresh page, marked three times and queried, plus a mark on a cell already at zero.
  // A low threshold with a large step makes the subtraction clamp at zero.
  task automatic test_config_sweep();
    logic [CFG_W-1:0] keep_set [7] = '{8'd0, 8'd255, 8'd10, 8'd254, 8'd255, 8'd0, 8'd60};
    logic [CFG_W-1:0] step_set [7] = '{8'd0, 8'd255, 8'd200, 8'd1, 8'd0, 8'd255, 8'd50};
    logic [31:0] p;
    for (int i = 0; i < 7; i++) begin
      wait_drained();
      set_config(keep_set[i], step_set[i]);
      p = point_in_page(1 + i, $urandom_range(0, PAGE_SPAN - 1),
                        $urandom_range(0, PAGE_SPAN - 1));
      repeat (3) send_item(CMD_MARK, p);
      send_item(CMD_QUERY, p);
      send_item(CMD_MARK, pack_point(0, 0));
    end
  endtask

  // Random marks and queries in chunks; each chunk starts from a drained
  // unit with new thresholds and a new pacing on both sides.
  task automatic test_random_traffic(input int n_items);
    cmd_t cmd;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        wait_drained();
        set_config(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)));
        src_pace  = draw_pace();
        sink_pace = draw_pace();
      end
      cmd = ($urandom_range(0, 99) < 60) ? CMD_MARK : CMD_QUERY;
      send_item(cmd, pick_point());
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering, so the internal queue fills and the input stalls.
  task automatic test_backpressure();
    wait_drained();
    src_pace = PACE_NONE;
    sink_pace = PACE_NONE;
    sink_hold_cycles = LONG_HOLD;
    repeat (12) send_item($urandom_range(0, 1) ? CMD_MARK : CMD_QUERY, pick_point());
  endtask

  // Back-to-back bursts separated by a full drain of the results.
  task automatic test_drain();
    src_pace = PACE_NONE;
    sink_pace = PACE_SPARSE;
    repeat (10) send_item(CMD_MARK, pick_point());
    wait_drained();
    repeat (10) send_item(CMD_QUERY, pick_point());
  endtask

  // Marks every unallocated page in turn until the pool is spent and a few
  // more marks are refused, then queries one of the refused pages.
  task automatic test_pool_exhaust();
    int refused;
    int last_dir;
    refused = 0;
    last_dir = 0;
    src_pace = PACE_SPARSE;
    sink_pace = PACE_SPARSE;
    for (int d = 0; d < DIR_ENTRIES && refused < 6; d++) begin
      if (!page_valid[d]) begin
        if (pages_taken >= POOL_PAGES) refused++;
        last_dir = d;
        send_item(CMD_MARK, point_in_page(d, $urandom_range(0, PAGE_SPAN - 1),
                                          $urandom_range(0, PAGE_SPAN - 1)));
      end
    end
    send_item(CMD_QUERY, point_in_page(last_dir, 0, 0));
  endtask

  // Result side: takes a result whenever offered, idles after each
  // transaction as the current pacing says, and obeys a requested hold-off.
  initial begin : result_sink
    int pause;
    bit took;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk);
      took = m_axis_tvalid && m_axis_tready;
      if (sink_hold_cycles > 0) begin
        pause = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else if (took) begin
        pause = draw_gap(sink_pace);
      end else begin
        pause = 0;
      end
      if (pause > 0) begin
        m_axis_tready <= 1'b0;
        repeat (pause) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Every result transaction is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    cell_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_cells.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: value %0d status %0d",
                                m_axis_tdata, m_axis_tuser));
      end else begin
        want = expected_cells.pop_front();
        if (m_axis_tdata !== want.value || m_axis_tuser !== want.status) begin
          note_mismatch($sformatf("expected value %0d status %s, got value %0d status %0d",
                                  want.value, want.status.name(), m_axis_tdata,
                                  m_axis_tuser));
        end
      end
    end
  end

  // Hang detection: too long without a transaction on either stream.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst           <= 1'b1;
    cfg_wen       <= 1'b0;
    cfg_addr      <= REG_KEEP_ABOVE;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_MARK;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_config_sweep();
    test_random_traffic(180);
    test_backpressure();
    test_drain();
    test_pool_exhaust();
    test_random_traffic(200);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
